/* rtl/core/brl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types and constants of the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int MAX_SIDE   = 64;
    localparam int IN_W       = 6;
    localparam int COORD_W    = 7;
    localparam int SIDE_W     = 7;
    localparam int DELTA_W    = 7;
    localparam int ERR_W      = 11;
    localparam int ADDR_W     = 13;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 4;

    localparam logic [SIDE_W-1:0] SIDE_MAX     = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0] WIDTH_RESET  = SIDE_W'(64);
    localparam logic [SIDE_W-1:0] HEIGHT_RESET = SIDE_W'(32);
    localparam logic [CNT_W-1:0]  LAST_COUNT   = {CNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = CFG_IDX_W'(1);

    // one segment as the front end hands it to the stepper
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [DELTA_W-1:0]        dx;
        logic [DELTA_W-1:0]        dy;
        logic                      sx_neg;
        logic                      sy_neg;
    } line_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } back_state_t;

endpackage

/* rtl/core/bresenham_line_rasterizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// Turns a segment in centered world coordinates into its screen points.
// ----------------------------------------------------------------------------
// A segment is taken when start is high and busy is low; it goes into a
// two-entry queue, and busy is high only while that queue is full. The
// stepper loads one segment from the queue while idle and then issues one
// point per cycle until a segment of n points (1 to 64) is done; it loads
// the next only after that; each point leaves through an output register.
// Each point is shown for exactly one cycle with point_valid high and cannot
// be held off, so the receiver must take every point as it comes. Canvas
// size is written through the cfg port (cfg_ready is always high); values
// above 64 are clamped, and writes belong only to times when no segment is
// queued or in progress.
module bresenham_line_rasterizer_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [brl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [brl_pkg::SIDE_W-1:0]            cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [brl_pkg::IN_W-1:0]       start_x,
    input  logic signed [brl_pkg::IN_W-1:0]       start_y,
    input  logic signed [brl_pkg::IN_W-1:0]       end_x,
    input  logic signed [brl_pkg::IN_W-1:0]       end_y,
    output logic                                  point_valid,
    output logic signed [brl_pkg::COORD_W-1:0]    pixel_x,
    output logic signed [brl_pkg::COORD_W-1:0]    pixel_y,
    output logic                                  visible,
    output logic [brl_pkg::ADDR_W-1:0]            pixel_address,
    output logic                                  last_point
);
    import brl_pkg::*;

    q_status_t          q_status;
    line_t              push_line, pop_line;
    logic               push, pop;
    logic [SIDE_W-1:0]  canvas_width, canvas_height;

    assign cfg_ready = 1'b1;
    assign busy      = q_status.full;

    brl_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .q_status      (q_status),
        .push          (push),
        .push_line     (push_line),
        .canvas_width  (canvas_width),
        .canvas_height (canvas_height)
    );

    brl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_line (push_line),
        .pop       (pop),
        .pop_line  (pop_line),
        .q_status  (q_status)
    );

    brl_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop_line      (pop_line),
        .canvas_width  (canvas_width),
        .canvas_height (canvas_height),
        .pop           (pop),
        .point_valid   (point_valid),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .visible       (visible),
        .pixel_address (pixel_address),
        .last_point    (last_point)
    );

endmodule

/* rtl/core/brl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_front
// Canvas registers, item accept, endpoint shift to screen space and
// classification of each segment (deltas, step directions).
// ----------------------------------------------------------------------------
module brl_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [brl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [brl_pkg::SIDE_W-1:0]            cfg_data,
    input  logic                                  start,
    input  logic signed [brl_pkg::IN_W-1:0]       start_x,
    input  logic signed [brl_pkg::IN_W-1:0]       start_y,
    input  logic signed [brl_pkg::IN_W-1:0]       end_x,
    input  logic signed [brl_pkg::IN_W-1:0]       end_y,
    input  brl_pkg::q_status_t                    q_status,
    output logic                                  push,
    output brl_pkg::line_t                        push_line,
    output logic [brl_pkg::SIDE_W-1:0]            canvas_width,
    output logic [brl_pkg::SIDE_W-1:0]            canvas_height
);
    import brl_pkg::*;

    logic [SIDE_W-1:0]          width_reg, width_next;
    logic [SIDE_W-1:0]          height_reg, height_next;
    logic [SIDE_W-1:0]          cfg_sat;
    logic signed [COORD_W-1:0]  half_w, half_h;
    logic signed [COORD_W-1:0]  x1, y1, x2, y2;
    logic signed [COORD_W:0]    diff_x, diff_y;

    assign cfg_sat = (cfg_data > SIDE_MAX) ? SIDE_MAX : cfg_data;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            if (cfg_index == REG_CANVAS_WIDTH)
                width_next = cfg_sat;
            else if (cfg_index == REG_CANVAS_HEIGHT)
                height_next = cfg_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign canvas_width  = width_reg;
    assign canvas_height = height_reg;

    // halves stay at or below 32, so they are non-negative as signed values
    assign half_w = $signed({1'b0, width_reg[SIDE_W-1:1]});
    assign half_h = $signed({1'b0, height_reg[SIDE_W-1:1]});

    assign x1 = COORD_W'(start_x) + half_w;
    assign y1 = COORD_W'(start_y) + half_h;
    assign x2 = COORD_W'(end_x) + half_w;
    assign y2 = COORD_W'(end_y) + half_h;

    assign diff_x = (COORD_W+1)'(x2) - (COORD_W+1)'(x1);
    assign diff_y = (COORD_W+1)'(y2) - (COORD_W+1)'(y1);

    always_comb
    begin
        push_line.x1     = x1;
        push_line.y1     = y1;
        push_line.x2     = x2;
        push_line.y2     = y2;
        push_line.dx     = diff_x[COORD_W] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
        push_line.dy     = diff_y[COORD_W] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);
        push_line.sx_neg = !(x1 < x2);
        push_line.sy_neg = !(y1 < y2);
    end

    assign push = start && !q_status.full;

endmodule

/* rtl/core/brl_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_queue
// Two-entry segment queue between the front end and the stepper.
// ----------------------------------------------------------------------------
module brl_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  brl_pkg::line_t       push_line,
    input  logic                 pop,
    output brl_pkg::line_t       pop_line,
    output brl_pkg::q_status_t   q_status
);
    import brl_pkg::*;

    line_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign q_status.empty = (count_reg == 2'd0);
    assign q_status.full  = (count_reg == 2'd2);

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_line;
    end

    assign pop_line = entry_reg[rd_ptr_reg];

endmodule

/* rtl/core/brl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_back
// Bresenham stepper, one point per cycle, followed by a registered stage
// that works out visibility and the buffer address.
// ----------------------------------------------------------------------------
module brl_back
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  brl_pkg::q_status_t                    q_status,
    input  brl_pkg::line_t                        pop_line,
    input  logic [brl_pkg::SIDE_W-1:0]            canvas_width,
    input  logic [brl_pkg::SIDE_W-1:0]            canvas_height,
    output logic                                  pop,
    output logic                                  point_valid,
    output logic signed [brl_pkg::COORD_W-1:0]    pixel_x,
    output logic signed [brl_pkg::COORD_W-1:0]    pixel_y,
    output logic                                  visible,
    output logic [brl_pkg::ADDR_W-1:0]            pixel_address,
    output logic                                  last_point
);
    import brl_pkg::*;

    back_state_t                state_reg, state_next;
    logic signed [COORD_W-1:0]  x_reg, x_next;
    logic signed [COORD_W-1:0]  y_reg, y_next;
    logic signed [COORD_W-1:0]  x2_reg, x2_next;
    logic signed [COORD_W-1:0]  y2_reg, y2_next;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic [DELTA_W-1:0]         dx_reg, dx_next;
    logic [DELTA_W-1:0]         dy_reg, dy_next;
    logic                       sx_neg_reg, sx_neg_next;
    logic                       sy_neg_reg, sy_neg_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    logic signed [ERR_W-1:0]    e2, dx_s, dy_s;
    logic signed [COORD_W-1:0]  step_x, step_y;
    logic                       emit, is_last, vis;
    logic [ADDR_W-1:0]          addr;

    logic                       out_valid_reg;
    logic signed [COORD_W-1:0]  out_x_reg, out_y_reg;
    logic                       out_vis_reg, out_last_reg;
    logic [ADDR_W-1:0]          out_addr_reg;

    assign dx_s   = $signed(ERR_W'(dx_reg));
    assign dy_s   = $signed(ERR_W'(dy_reg));
    assign e2     = err_reg <<< 1;
    assign step_x = sx_neg_reg ? -COORD_W'(1) : COORD_W'(1);
    assign step_y = sy_neg_reg ? -COORD_W'(1) : COORD_W'(1);
    assign is_last = ((x_reg == x2_reg) && (y_reg == y2_reg)) || (cnt_reg == LAST_COUNT);

    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        x2_next     = x2_reg;
        y2_next     = y2_reg;
        err_next    = err_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        cnt_next    = cnt_reg;
        pop         = 1'b0;
        emit        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop         = 1'b1;
                    x_next      = pop_line.x1;
                    y_next      = pop_line.y1;
                    x2_next     = pop_line.x2;
                    y2_next     = pop_line.y2;
                    dx_next     = pop_line.dx;
                    dy_next     = pop_line.dy;
                    sx_neg_next = pop_line.sx_neg;
                    sy_neg_next = pop_line.sy_neg;
                    err_next    = $signed(ERR_W'(pop_line.dx)) - $signed(ERR_W'(pop_line.dy));
                    cnt_next    = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                emit = 1'b1;
                if (is_last)
                    state_next = ST_IDLE;
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    // both tests use the error from before this step
                    if (e2 > -dy_s && e2 < dx_s)
                    begin
                        err_next = err_reg - dy_s + dx_s;
                        x_next   = x_reg + step_x;
                        y_next   = y_reg + step_y;
                    end
                    else if (e2 > -dy_s)
                    begin
                        err_next = err_reg - dy_s;
                        x_next   = x_reg + step_x;
                    end
                    else if (e2 < dx_s)
                    begin
                        err_next = err_reg + dx_s;
                        y_next   = y_reg + step_y;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        x2_reg     <= x2_next;
        y2_reg     <= y2_next;
        err_reg    <= err_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        cnt_reg    <= cnt_next;
    end

    // visible points have x below the canvas width and y below the canvas height, so both lie in 0..63
    assign vis = !x_reg[COORD_W-1] && !y_reg[COORD_W-1]
              && ($unsigned(x_reg) < canvas_width)
              && ($unsigned(y_reg) < canvas_height);

    assign addr = vis ? (ADDR_W'(y_reg[COORD_W-2:0]) * ADDR_W'(canvas_width + SIDE_W'(1))
                         + ADDR_W'(x_reg[COORD_W-2:0]))
                      : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        out_x_reg    <= x_reg;
        out_y_reg    <= y_reg;
        out_vis_reg  <= vis;
        out_addr_reg <= addr;
        out_last_reg <= is_last;
    end

    assign point_valid   = out_valid_reg;
    assign pixel_x       = out_x_reg;
    assign pixel_y       = out_y_reg;
    assign visible       = out_vis_reg;
    assign pixel_address = out_addr_reg;
    assign last_point    = out_last_reg;

endmodule

/* rtl/core/brl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_checker
// Port-level checks on the point stream of the line rasterizer.
// ----------------------------------------------------------------------------
module brl_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  point_valid,
    input  logic signed [brl_pkg::COORD_W-1:0]    pixel_x,
    input  logic signed [brl_pkg::COORD_W-1:0]    pixel_y,
    input  logic                                  visible,
    input  logic [brl_pkg::ADDR_W-1:0]            pixel_address,
    input  logic                                  last_point
);
    import brl_pkg::*;

    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic [COORD_W-1:0]        dx_step, dy_step;

    always_ff @(posedge clk)
    begin
        prev_x_reg <= pixel_x;
        prev_y_reg <= pixel_y;
    end

    assign dx_step = pixel_x - prev_x_reg;
    assign dy_step = pixel_y - prev_y_reg;

    a_vis_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && visible |-> !pixel_x[COORD_W-1] && !pixel_y[COORD_W-1])
        else $error("visible point with negative coordinate");

    a_hidden_addr: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !visible |-> pixel_address == '0)
        else $error("hidden point with nonzero address");

    // within a segment each step moves at most one unit per axis
    a_step_x: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && $past(point_valid) && !$past(last_point)
        |-> dx_step == '0 || dx_step == COORD_W'(1) || dx_step == '1)
        else $error("x jumped by more than one");

    a_step_y: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && $past(point_valid) && !$past(last_point)
        |-> dy_step == '0 || dy_step == COORD_W'(1) || dy_step == '1)
        else $error("y jumped by more than one");

endmodule

bind bresenham_line_rasterizer_unit brl_checker u_brl_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .point_valid   (point_valid),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .visible       (visible),
    .pixel_address (pixel_address),
    .last_point    (last_point)
);
